// ===== rtl/character_lcd_4bit_sequencer_defines.svh =====
// Assertion macros shared by the checker of the character display sequencer.
// No dependencies; include by bare file name.
`ifndef CHARACTER_LCD_4BIT_SEQUENCER_DEFINES_SVH
`define CHARACTER_LCD_4BIT_SEQUENCER_DEFINES_SVH

// Property checked at every rising edge outside reset.
`define LCD4_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: property failed");

// Property checked at every rising edge, reset included.
`define LCD4_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: property failed");

`endif

// ===== rtl/lcd4_pkg.sv =====
// Types, codes and constant tables for the character display sequencer.
// No dependencies.
package lcd4_pkg;

    localparam logic [2:0] REQ_CMD    = 3'd0;
    localparam logic [2:0] REQ_DATA   = 3'd1;
    localparam logic [2:0] REQ_CURSOR = 3'd2;
    localparam logic [2:0] REQ_CLEAR  = 3'd3;
    localparam logic [2:0] REQ_INIT   = 3'd4;

    localparam logic [16:0] HOLD_SETUP   = 17'd1;
    localparam logic [16:0] HOLD_STROBE  = 17'd10;
    localparam logic [16:0] HOLD_SETTLE  = 17'd100;
    localparam logic [16:0] HOLD_POWERUP = 17'd100000;
    localparam logic [16:0] EXTRA_CLEAR  = 17'd2000;

    localparam logic [7:0] CMD_CLEAR   = 8'h01;
    localparam logic [7:0] CMD_SET_DDR = 8'h80;
    localparam logic [7:0] ROW1_BASE   = 8'h40;
    localparam logic [7:0] MAX_COLUMN  = 8'd15;

    // Index of the last nibble of the power-on sequence after the initial wait.
    localparam logic [3:0] INIT_LAST_NIB = 4'd13;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] byte_value;
        logic [7:0] row;
        logic [7:0] column;
    } req_t;

    typedef struct packed {
        logic        reg_select;
        logic [3:0]  data_nibble;
        logic        enable;
        logic [16:0] hold_us;
        logic        last;
    } step_t;

    typedef struct packed {
        logic       is_init;
        logic       rs;
        logic       clear;
        logic [7:0] byte_val;
    } job_t;

    function automatic logic [3:0] init_nibble(input logic [3:0] idx);
        logic [3:0] nib;
        case (idx)
            4'd0:    nib = 4'h3;
            4'd1:    nib = 4'h3;
            4'd2:    nib = 4'h3;
            4'd3:    nib = 4'h2;
            4'd4:    nib = 4'h2;
            4'd5:    nib = 4'h8;
            4'd6:    nib = 4'h0;
            4'd7:    nib = 4'h8;
            4'd8:    nib = 4'h0;
            4'd9:    nib = 4'h1;
            4'd10:   nib = 4'h0;
            4'd11:   nib = 4'h6;
            4'd12:   nib = 4'h0;
            4'd13:   nib = 4'hC;
            default: nib = 4'h0;
        endcase
        return nib;
    endfunction

    function automatic logic [16:0] init_extra(input logic [3:0] idx);
        logic [16:0] ext;
        case (idx)
            4'd0:    ext = 17'd10000;
            4'd1:    ext = 17'd200;
            4'd2:    ext = 17'd200;
            4'd3:    ext = 17'd200;
            4'd9:    ext = 17'd5000;
            default: ext = 17'd0;
        endcase
        return ext;
    endfunction

endpackage

// ===== rtl/character_lcd_4bit_sequencer.sv =====
// Four-bit character display sequencer: one request in, a run of pin steps out.
// A request's first step passes the job queue, job_reg and the result queue.
// Throughput: one step per cycle while the result queue is not full; a byte,
// cursor or clear request makes 6 steps, power-on 43 and unknown types none.
// Reset: asynchronous, active low; it empties both queues and idles the sequencer.
// Depends on lcd4_pkg, lcd4_front, lcd4_fifo and lcd4_back.
module character_lcd_4bit_sequencer #(
    parameter int JOB_DEPTH  = 2,
    parameter int STEP_DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    output logic            full,
    input  lcd4_pkg::req_t  req,
    output logic            empty,
    input  logic            pop,
    output lcd4_pkg::step_t result
);
    import lcd4_pkg::*;

    // Front side: classify the request; unknown types are accepted and dropped.
    job_t job_in;
    logic known;

    lcd4_front u_front (
        .req   (req),
        .job   (job_in),
        .known (known)
    );

    // Job queue: decouples acceptance from the step sequencer.
    job_t job_head;
    logic job_empty;
    logic job_full;
    logic job_take;

    assign full = job_full;

    lcd4_fifo #(
        .WIDTH ($bits(job_t)),
        .DEPTH (JOB_DEPTH)
    ) u_job_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push && known),
        .wdata (job_in),
        .full  (job_full),
        .pop   (job_take),
        .rdata (job_head),
        .empty (job_empty)
    );

    // Back side: walk the nibbles and strobe phases of the current job, and
    // load the next job on the cycle that emits the last step of this one.
    step_t step;
    logic  step_valid;
    logic  step_full;

    lcd4_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (job_head),
        .job_valid  (!job_empty),
        .job_take   (job_take),
        .step       (step),
        .step_valid (step_valid),
        .step_full  (step_full)
    );

    // Result queue: holds finished steps so a stalled consumer does not block
    // the sequencer until it fills.
    lcd4_fifo #(
        .WIDTH ($bits(step_t)),
        .DEPTH (STEP_DEPTH)
    ) u_step_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (step_valid),
        .wdata (step),
        .full  (step_full),
        .pop   (pop),
        .rdata (result),
        .empty (empty)
    );
endmodule

// ===== rtl/lcd4_fifo.sv =====
// Small register queue with first-word fall-through output.
// No package dependencies.
module lcd4_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end
endmodule

// ===== rtl/lcd4_front.sv =====
// Request classifier: turns a request into a job for the step sequencer.
// Depends on lcd4_pkg.
module lcd4_front (
    input  lcd4_pkg::req_t req,
    output lcd4_pkg::job_t job,
    output logic           known
);
    import lcd4_pkg::*;

    logic [7:0] row_base;
    logic [7:0] col_clamped;

    assign row_base    = (req.row == 8'd0) ? 8'h00 : ROW1_BASE;
    assign col_clamped = (req.column > MAX_COLUMN) ? MAX_COLUMN : req.column;

    always_comb
    begin
        job   = '0;
        known = 1'b1;
        case (req.req_type)
            REQ_CMD:
            begin
                job.byte_val = req.byte_value;
            end
            REQ_DATA:
            begin
                job.rs       = 1'b1;
                job.byte_val = req.byte_value;
            end
            REQ_CURSOR:
            begin
                job.byte_val = CMD_SET_DDR | (row_base + col_clamped);
            end
            REQ_CLEAR:
            begin
                job.clear    = 1'b1;
                job.byte_val = CMD_CLEAR;
            end
            REQ_INIT:
            begin
                job.is_init = 1'b1;
            end
            default:
            begin
                // drop unknown request types
                known = 1'b0;
            end
        endcase
    end
endmodule

// ===== rtl/lcd4_back.sv =====
// Step sequencer: expands one job into pin steps, one step per cycle while step_full is low.
// Depends on lcd4_pkg.
module lcd4_back (
    input  logic            clk,
    input  logic            rst_n,
    input  lcd4_pkg::job_t  job,
    input  logic            job_valid,
    output logic            job_take,
    output lcd4_pkg::step_t step,
    output logic            step_valid,
    input  logic            step_full
);
    import lcd4_pkg::*;

    logic       busy_reg, busy_next;
    logic       wait_reg, wait_next;
    logic [3:0] nib_reg, nib_next;
    logic [1:0] phase_reg, phase_next;
    job_t       job_reg, job_next;

    logic [3:0]  cur_nib;
    logic [16:0] extra;
    logic        emit;

    always_comb
    begin
        if (job_reg.is_init)
        begin
            cur_nib = init_nibble(nib_reg);
            extra   = init_extra(nib_reg);
        end
        else
        begin
            cur_nib = nib_reg[0] ? job_reg.byte_val[3:0] : job_reg.byte_val[7:4];
            extra   = (job_reg.clear && nib_reg[0]) ? EXTRA_CLEAR : 17'd0;
        end

        step = '0;
        if (wait_reg)
        begin
            step.hold_us = HOLD_POWERUP;
        end
        else
        begin
            step.reg_select  = job_reg.rs;
            step.data_nibble = cur_nib;
            step.enable      = (phase_reg == 2'd1);
            case (phase_reg)
                2'd0:    step.hold_us = HOLD_SETUP;
                2'd1:    step.hold_us = HOLD_STROBE;
                default: step.hold_us = HOLD_SETTLE + extra;
            endcase
            step.last = (phase_reg == 2'd2) &&
                        (nib_reg == (job_reg.is_init ? INIT_LAST_NIB : 4'd1));
        end
    end

    assign emit       = busy_reg && !step_full;
    assign step_valid = emit;
    assign job_take   = job_valid && (!busy_reg || (emit && step.last));

    always_comb
    begin
        busy_next  = busy_reg;
        wait_next  = wait_reg;
        nib_next   = nib_reg;
        phase_next = phase_reg;
        job_next   = job_reg;
        if (emit)
        begin
            if (wait_reg)
            begin
                wait_next = 1'b0;
            end
            else if (phase_reg == 2'd2)
            begin
                phase_next = 2'd0;
                nib_next   = nib_reg + 1'b1;
                if (step.last)
                begin
                    busy_next = 1'b0;
                end
            end
            else
            begin
                phase_next = phase_reg + 1'b1;
            end
        end
        if (job_take)
        begin
            busy_next  = 1'b1;
            wait_next  = job.is_init;
            nib_next   = '0;
            phase_next = '0;
            job_next   = job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            wait_reg  <= 1'b0;
            nib_reg   <= '0;
            phase_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            wait_reg  <= wait_next;
            nib_reg   <= nib_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
    end
endmodule

// ===== rtl/lcd4_checker.sv =====
// Port-level checks for the character display sequencer, bound to the top level.
// Depends on lcd4_pkg and character_lcd_4bit_sequencer_defines.svh.
`include "character_lcd_4bit_sequencer_defines.svh"

module lcd4_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            empty,
    input logic            pop,
    input lcd4_pkg::step_t result
);
    import lcd4_pkg::*;

    // reset leaves no result waiting
    `LCD4_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> empty)
    // a strobe-high step is the short one and never ends a request
    `LCD4_ASSERT(a_strobe_hold, clk, rst_n, !empty && result.enable |-> result.hold_us == HOLD_STROBE && !result.last)
    // a request ends on a settle step with enable low
    `LCD4_ASSERT(a_last_settle, clk, rst_n, !empty && result.last |-> !result.enable && result.hold_us >= HOLD_SETTLE)
    // a waiting result that is not taken stays
    `LCD4_ASSERT(a_hold_result, clk, rst_n, !empty && !pop |=> !empty && $stable(result))
endmodule

bind character_lcd_4bit_sequencer lcd4_checker u_lcd4_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
